/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cle_pkg.sv */
package cle_pkg;

  localparam int RING_DEPTH_DEF = 32;

  localparam int STEP_W = 5;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  // program entry points
  localparam step_t ST_DISPATCH = 5'd0;
  localparam step_t ST_IGNORE   = 5'd5;
  localparam step_t ST_EOL      = 5'd6;
  localparam step_t ST_ERASE    = 5'd8;
  localparam step_t ST_ESC      = 5'd12;
  localparam step_t ST_PRINT    = 5'd13;
  localparam step_t ST_SWALLOW  = 5'd16;
  localparam step_t ST_BELL     = 5'd17;
  localparam step_t ST_READ     = 5'd18;
  localparam step_t ST_LOOP     = 5'd20;
  localparam step_t ST_EXIT     = 5'd25;
  localparam step_t ST_NOLINE   = 5'd26;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IS_READ,
    C_IS_EOL,
    C_IS_ERASE,
    C_IS_ESC,
    C_IS_PRINT,
    C_ESC_ARMED,
    C_FULL,
    C_EMPTY,
    C_NOT_READY,
    C_IDX_AT_LIM,
    C_DATA_EOL
  } cond_t;

  typedef enum logic [2:0] {
    B_ZERO,
    B_CR,
    B_LF,
    B_BS,
    B_SP,
    B_BEL,
    B_RX,
    B_DATA
  } bsel_t;

  typedef struct packed {
    cond_t      cond;
    step_t      target;
    logic       emit;
    logic [1:0] kind;
    bsel_t      bsel;
    logic       cnt_idx;   // count field is idx+1, else zero
    logic       last;
    logic       done;
    logic       store;
    logic       wdec;
    logic       rd;        // read ring at rptr, advance rptr
    logic       esc_set;
    logic       esc_clr;
    logic       rdy_set;
    logic       rdy_clr;
    logic       idx_clr;
    logic       idx_inc;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    w.cond = C_NEVER;
    w.bsel = B_ZERO;
    unique case (s)
      5'd0:  begin w.cond = C_IS_READ;  w.target = ST_READ;  end
      5'd1:  begin w.cond = C_IS_EOL;   w.target = ST_EOL;   end
      5'd2:  begin w.cond = C_IS_ERASE; w.target = ST_ERASE; end
      5'd3:  begin w.cond = C_IS_ESC;   w.target = ST_ESC;   end
      5'd4:  begin w.cond = C_IS_PRINT; w.target = ST_PRINT; end
      5'd5:  begin w.done = 1'b1; end
      // line end: echo cr lf, store terminator unchecked
      5'd6:  begin w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = B_CR; end
      5'd7:  begin
        w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = B_LF; w.last = 1'b1;
        w.store = 1'b1; w.rdy_set = 1'b1; w.done = 1'b1;
      end
      // erase
      5'd8:  begin w.esc_clr = 1'b1; w.cond = C_EMPTY; w.target = ST_IGNORE; end
      5'd9:  begin w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = B_BS; end
      5'd10: begin w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = B_SP; end
      5'd11: begin
        w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = B_BS; w.last = 1'b1;
        w.wdec = 1'b1; w.done = 1'b1;
      end
      5'd12: begin w.esc_set = 1'b1; w.done = 1'b1; end
      // printable
      5'd13: begin w.cond = C_ESC_ARMED; w.target = ST_SWALLOW; end
      5'd14: begin w.cond = C_FULL; w.target = ST_BELL; end
      5'd15: begin
        w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = B_RX; w.last = 1'b1;
        w.store = 1'b1; w.done = 1'b1;
      end
      5'd16: begin w.esc_clr = 1'b1; w.done = 1'b1; end
      5'd17: begin
        w.emit = 1'b1; w.kind = KIND_ECHO; w.bsel = B_BEL; w.last = 1'b1;
        w.done = 1'b1;
      end
      // read request
      5'd18: begin w.cond = C_NOT_READY; w.target = ST_NOLINE; end
      5'd19: begin w.rdy_clr = 1'b1; w.idx_clr = 1'b1; end
      5'd20: begin w.cond = C_IDX_AT_LIM; w.target = ST_EXIT; end
      5'd21: begin w.cond = C_EMPTY; w.target = ST_EXIT; end
      5'd22: begin w.rd = 1'b1; end
      5'd23: begin
        w.emit = 1'b1; w.kind = KIND_DATA; w.bsel = B_DATA;
        w.cond = C_DATA_EOL; w.target = ST_EXIT;
      end
      5'd24: begin w.idx_inc = 1'b1; w.cond = C_ALWAYS; w.target = ST_LOOP; end
      5'd25: begin
        w.emit = 1'b1; w.kind = KIND_DONE; w.cnt_idx = 1'b1; w.last = 1'b1;
        w.done = 1'b1;
      end
      5'd26: begin
        w.emit = 1'b1; w.kind = KIND_DONE; w.last = 1'b1; w.done = 1'b1;
      end
      default: begin w.done = 1'b1; end
    endcase
    return w;
  endfunction

endpackage

/* rtl/console_line_editor.sv */
// console receive line editor over a byte ring. an item is taken when start is
// high and busy is low; the block then runs a short microprogram, one step per
// cycle, and raises out_valid for one cycle per result with no way for the
// receiver to hold it off, so it must take every transfer as it comes. a
// received byte runs the dispatch chain of the program and then its handler; a
// read request with no line ready gives only a done result, else it pops
// bytes through the loop of limit check, empty check, ring read, data emit and
// index step until it stops on a terminator, at max_len or when the ring runs
// dry. out_last marks the final result of an item, and busy drops in the same
// cycle that this last result is shown, so the next start can follow at once.
// no clearing pass after reset: the ring discipline never pops an entry that
// was never written.
module console_line_editor #(
  parameter int RING_DEPTH = cle_pkg::RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  input  logic [5:0] in_max_len,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [6:0] out_count,
  output logic       out_last
);
  import cle_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  // latched item
  logic       op_r;
  logic [7:0] byte_r;
  logic [5:0] lim_r;

  // sequencer
  logic  busy_r, busy_nxt;
  step_t step_r, step_nxt;
  ctrl_t cw;
  logic  cond_hit;

  // datapath state
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic          ready_r, ready_nxt;
  logic          esc_r, esc_nxt;
  logic [5:0]    idx_r, idx_nxt;
  logic [7:0]    rdata_r;

  // byte ring
  logic [7:0] line_store_r [RING_DEPTH];

  // result registers
  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_byte_r;
  logic [6:0] out_count_r;
  logic       out_last_r;
  logic [7:0] byte_sel;

  logic empty, full, data_eol, accept;
  logic [PW-1:0] wptr_inc, rptr_inc;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign accept   = start && !busy_r;
  assign wptr_inc = ring_next(wptr_r);
  assign rptr_inc = ring_next(rptr_r);
  assign empty    = (wptr_r == rptr_r);
  assign full     = (wptr_inc == rptr_r);
  assign data_eol = (rdata_r == CH_CR) || (rdata_r == CH_LF);

  // current control word
  assign cw = ucode(step_r);

  // jump condition select
  always_comb begin
    case (cw.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_IS_READ:    cond_hit = op_r;
      C_IS_EOL:     cond_hit = (byte_r == CH_CR) || (byte_r == CH_LF);
      C_IS_ERASE:   cond_hit = (byte_r == CH_BS) || (byte_r == CH_DEL);
      C_IS_ESC:     cond_hit = (byte_r == CH_ESC);
      C_IS_PRINT:   cond_hit = (byte_r >= CH_SP);
      C_ESC_ARMED:  cond_hit = esc_r;
      C_FULL:       cond_hit = full;
      C_EMPTY:      cond_hit = empty;
      C_NOT_READY:  cond_hit = !ready_r;
      C_IDX_AT_LIM: cond_hit = (idx_r >= lim_r);
      C_DATA_EOL:   cond_hit = data_eol;
      default:      cond_hit = 1'b0;
    endcase
  end

  // byte source for emitted results; a popped terminator goes out as zero
  always_comb begin
    case (cw.bsel)
      B_ZERO:  byte_sel = 8'h00;
      B_CR:    byte_sel = CH_CR;
      B_LF:    byte_sel = CH_LF;
      B_BS:    byte_sel = CH_BS;
      B_SP:    byte_sel = CH_SP;
      B_BEL:   byte_sel = CH_BEL;
      B_RX:    byte_sel = byte_r;
      B_DATA:  byte_sel = data_eol ? 8'h00 : rdata_r;
      default: byte_sel = 8'h00;
    endcase
  end

  // next state for sequencer and datapath registers
  always_comb begin
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    ready_nxt = ready_r;
    esc_nxt   = esc_r;
    idx_nxt   = idx_r;
    if (!busy_r) begin
      if (accept) begin
        busy_nxt = 1'b1;
        step_nxt = ST_DISPATCH;
      end
    end else begin
      // step counter with conditional jump, program end parks the sequencer
      if (cw.done) begin
        busy_nxt = 1'b0;
        step_nxt = ST_DISPATCH;
      end else if (cond_hit) begin
        step_nxt = cw.target;
      end else begin
        step_nxt = step_r + 1'b1;
      end
      if (cw.store)   wptr_nxt = wptr_inc;
      if (cw.wdec)    wptr_nxt = (wptr_r == '0) ? PTR_LAST : wptr_r - 1'b1;
      if (cw.rd)      rptr_nxt = rptr_inc;
      if (cw.rdy_set) ready_nxt = 1'b1;
      if (cw.rdy_clr) ready_nxt = 1'b0;
      if (cw.esc_set) esc_nxt = 1'b1;
      if (cw.esc_clr) esc_nxt = 1'b0;
      if (cw.idx_clr) idx_nxt = '0;
      if (cw.idx_inc) idx_nxt = idx_r + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_DISPATCH;
      rptr_r      <= '0;
      wptr_r      <= '0;
      ready_r     <= 1'b0;
      esc_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      ready_r     <= ready_nxt;
      esc_r       <= esc_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= busy_r && cw.emit;
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      byte_r <= in_rx_byte;
      lim_r  <= in_max_len;
    end
    if (busy_r && cw.emit) begin
      out_kind_r  <= cw.kind;
      out_byte_r  <= byte_sel;
      out_count_r <= cw.cnt_idx ? ({1'b0, idx_r} + 7'd1) : 7'd0;
      out_last_r  <= cw.last;
    end
  end

  // ring memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (busy_r && cw.store) begin
      line_store_r[wptr_r] <= byte_r;
    end
    if (busy_r && cw.rd) begin
      rdata_r <= line_store_r[rptr_r];
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/cle_checker.sv */
`include "assert_macros.svh"

module cle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic [6:0] out_count,
  input logic       out_last
);
  import cle_pkg::*;

  // a taken item is followed by busy in the next cycle
  `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept not followed by busy")

  // results before the last one come while the item is still in work
  `CHK_SAME(a_mid_busy, clk, rst_n, out_valid && !out_last, busy, "result after item end")

  // a read-finished result always closes its item
  `CHK_SAME(a_done_last, clk, rst_n, out_valid && (out_kind == KIND_DONE), out_last,
    "read finished without last")

  // count only on read-finished results
  `CHK_SAME(a_count_zero, clk, rst_n, out_valid && (out_kind != KIND_DONE),
    out_count == 7'd0, "count on echo or data result")

endmodule

bind console_line_editor cle_checker u_cle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_kind  (out_kind),
  .out_count (out_count),
  .out_last  (out_last)
);
